// ===== design/pinhole_point_projection_assert.svh =====
// ----------------------------------------------------------------------------
// pinhole_point_projection_assert.svh
// Assertion macros shared by the checker of the point projection block.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_POINT_PROJECTION_ASSERT_SVH
`define PINHOLE_POINT_PROJECTION_ASSERT_SVH

// Checked only while out of reset.
`define PPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Types, register indexes and helpers of the point projection pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam logic [2:0] REG_ROT_ROW0  = 3'd0;
  localparam logic [2:0] REG_ROT_ROW1  = 3'd1;
  localparam logic [2:0] REG_ROT_ROW2  = 3'd2;
  localparam logic [2:0] REG_TRANS_XY  = 3'd3;
  localparam logic [2:0] REG_TRANS_Z   = 3'd4;
  localparam logic [2:0] REG_FOCAL_XY  = 3'd5;
  localparam logic [2:0] REG_CENTER_XY = 3'd6;

  localparam logic [47:0] ROT_ROW0_RST = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW1_RST = 48'h0000_0000_4000;
  localparam logic [47:0] ROT_ROW2_RST = 48'h0000_0000_4000;

  localparam int QBITS = 32;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cam_t;

  typedef struct packed {
    cam_t        cam;
    logic        vis;
    logic [30:0] z;
    logic        sx;
    logic        sy;
    logic        ovx;
    logic        ovy;
    logic [30:0] remx;
    logic [30:0] remy;
    logic [31:0] lowx;
    logic [31:0] lowy;
    logic [31:0] qx;
    logic [31:0] qy;
  } div_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/ppp_xform.sv =====
// ----------------------------------------------------------------------------
// ppp_xform
// Rigid transform into the camera frame: products, then rounded saturated sums.
// ----------------------------------------------------------------------------
module ppp_xform (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] world_x,
  input  logic signed [31:0] world_y,
  input  logic signed [31:0] world_z,
  input  logic [47:0]        rot_row0,
  input  logic [47:0]        rot_row1,
  input  logic [47:0]        rot_row2,
  input  logic [63:0]        trans_xy,
  input  logic [31:0]        trans_z,
  output logic               out_valid,
  input  logic               out_ready,
  output ppp_pkg::cam_t      out_data
);
  import ppp_pkg::*;

  logic               v1_r, v2_r;
  logic               ld1, ld2;
  logic signed [47:0] p_r   [9];
  logic signed [47:0] p_nxt [9];
  logic [47:0]        rows  [3];
  logic signed [31:0] w     [3];
  logic signed [31:0] t     [3];
  cam_t               c_r, c_nxt;
  logic signed [31:0] res   [3];

  assign rows[0] = rot_row0;
  assign rows[1] = rot_row1;
  assign rows[2] = rot_row2;
  assign w[0]    = world_x;
  assign w[1]    = world_y;
  assign w[2]    = world_z;
  assign t[0]    = trans_xy[63:32];
  assign t[1]    = trans_xy[31:0];
  assign t[2]    = trans_z;

  assign ld2      = !v2_r || out_ready;
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_nxt[3*r+c] = $signed(rows[r][47-16*c -: 16]) * w[c];
      end
    end
  end

  // Sum is exact; adding half an LSB and flooring rounds ties upward.
  always_comb begin
    logic signed [49:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = {{2{p_r[3*r][47]}}, p_r[3*r]} + {{2{p_r[3*r+1][47]}}, p_r[3*r+1]}
          + {{2{p_r[3*r+2][47]}}, p_r[3*r+2]} + {{4{t[r][31]}}, t[r], 14'd0}
          + 50'sd8192;
      res[r] = sat32(acc[49:14]);
    end
    c_nxt.x = res[0];
    c_nxt.y = res[1];
    c_nxt.z = res[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) p_r <= p_nxt;
    if (ld2 && v1_r) c_r <= c_nxt;
  end

  assign out_valid = v2_r;
  assign out_data  = c_r;

endmodule

// ===== design/ppp_divstep.sv =====
// ----------------------------------------------------------------------------
// ppp_divstep
// One restoring division step: one quotient bit for each of the two axes.
// ----------------------------------------------------------------------------
module ppp_divstep (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ppp_pkg::div_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ppp_pkg::div_t  out_data
);
  import ppp_pkg::*;

  logic        v_r, ld;
  div_t        d_r, d_nxt;
  logic [31:0] rx, ry;
  logic        gx, gy;

  assign ld       = !v_r || out_ready;
  assign in_ready = ld;

  always_comb begin
    rx = {in_data.remx, in_data.lowx[31]};
    ry = {in_data.remy, in_data.lowy[31]};
    gx = rx >= {1'b0, in_data.z};
    gy = ry >= {1'b0, in_data.z};
    d_nxt      = in_data;
    d_nxt.remx = gx ? 31'(rx - {1'b0, in_data.z}) : rx[30:0];
    d_nxt.remy = gy ? 31'(ry - {1'b0, in_data.z}) : ry[30:0];
    d_nxt.lowx = {in_data.lowx[30:0], 1'b0};
    d_nxt.lowy = {in_data.lowy[30:0], 1'b0};
    d_nxt.qx   = {in_data.qx[30:0], gx};
    d_nxt.qy   = {in_data.qy[30:0], gy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && in_valid) d_r <= d_nxt;
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// ===== design/ppp_project.sv =====
// ----------------------------------------------------------------------------
// ppp_project
// Perspective divide: focal product, rounding offset, bit-serial divide, offset.
// ----------------------------------------------------------------------------
module ppp_project (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppp_pkg::cam_t      in_data,
  input  logic [63:0]        focal_xy,
  input  logic [63:0]        center_xy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_visible,
  output ppp_pkg::cam_t      out_cam,
  output logic signed [31:0] out_u,
  output logic signed [31:0] out_v
);
  import ppp_pkg::*;

  logic        v1_r, v2_r, vf_r;
  logic        ld1, ld2, ldf;
  cam_t        c1_r;
  logic        vis1_r, sx1_r, sy1_r;
  logic [63:0] prx_r, pry_r;
  logic [31:0] magx, magy;
  div_t        d2_r, d2_nxt;
  logic [64:0] numx, numy;

  logic        dv    [QBITS+1];
  logic        drdy  [QBITS+1];
  div_t        dd    [QBITS+1];

  logic               visf_r;
  cam_t               camf_r;
  logic signed [31:0] uf_r, vf_nxt_u, vf_nxt_v, vq_r;

  // Stage 1: magnitudes and focal products.
  assign magx = in_data.x[31] ? 32'(-in_data.x) : in_data.x;
  assign magy = in_data.y[31] ? 32'(-in_data.y) : in_data.y;

  assign ld2      = !v2_r || drdy[0];
  assign ld1      = !v1_r || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) begin
      c1_r   <= in_data;
      vis1_r <= (in_data.z > 32'sd0);
      sx1_r  <= in_data.x[31];
      sy1_r  <= in_data.y[31];
      prx_r  <= focal_xy[63:32] * magx;
      pry_r  <= focal_xy[31:0] * magy;
    end
  end

  // Stage 2: add half the divisor. A quotient of 2^32 or more saturates in any case.
  always_comb begin
    numx = {1'b0, prx_r} + {35'd0, c1_r.z[30:1]};
    numy = {1'b0, pry_r} + {35'd0, c1_r.z[30:1]};
    d2_nxt.cam  = c1_r;
    d2_nxt.vis  = vis1_r;
    d2_nxt.z    = c1_r.z[30:0];
    d2_nxt.sx   = sx1_r;
    d2_nxt.sy   = sy1_r;
    d2_nxt.ovx  = numx[64:32] >= {2'b0, c1_r.z[30:0]};
    d2_nxt.ovy  = numy[64:32] >= {2'b0, c1_r.z[30:0]};
    d2_nxt.remx = numx[62:32];
    d2_nxt.remy = numy[62:32];
    d2_nxt.lowx = numx[31:0];
    d2_nxt.lowy = numy[31:0];
    d2_nxt.qx   = '0;
    d2_nxt.qy   = '0;
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) d2_r <= d2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ldf) vf_r <= dv[QBITS];
    end
  end

  assign dv[0] = v2_r;
  assign dd[0] = d2_r;

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    ppp_divstep u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (dv[k]),
      .in_ready (drdy[k]),
      .in_data  (dd[k]),
      .out_valid(dv[k+1]),
      .out_ready(drdy[k+1]),
      .out_data (dd[k+1])
    );
  end

  // Final stage: sign, principal point, saturation.
  assign ldf         = !vf_r || out_ready;
  assign drdy[QBITS] = ldf;

  always_comb begin
    logic [33:0]        mx, my;
    logic signed [35:0] sxv, syv;
    mx  = dd[QBITS].ovx ? 34'h2_0000_0000 : {2'b0, dd[QBITS].qx};
    my  = dd[QBITS].ovy ? 34'h2_0000_0000 : {2'b0, dd[QBITS].qy};
    sxv = dd[QBITS].sx ? -$signed({2'b0, mx}) : $signed({2'b0, mx});
    syv = dd[QBITS].sy ? -$signed({2'b0, my}) : $signed({2'b0, my});
    vf_nxt_u = dd[QBITS].vis
             ? sat32(sxv + {{4{center_xy[63]}}, center_xy[63:32]}) : 32'sd0;
    vf_nxt_v = dd[QBITS].vis
             ? sat32(syv + {{4{center_xy[31]}}, center_xy[31:0]}) : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (ldf && dv[QBITS]) begin
      visf_r <= dd[QBITS].vis;
      camf_r <= dd[QBITS].cam;
      uf_r   <= vf_nxt_u;
      vq_r   <= vf_nxt_v;
    end
  end

  assign out_valid   = vf_r;
  assign out_visible = visf_r;
  assign out_cam     = camf_r;
  assign out_u       = uf_r;
  assign out_v       = vq_r;

endmodule

// ===== design/pinhole_point_projection.sv =====
// ----------------------------------------------------------------------------
// pinhole_point_projection
// Camera-frame transform and pinhole projection of world points, Q16.16.
// ----------------------------------------------------------------------------
// Usage: a world point is presented on in_world_x/y/z with in_valid and is
// taken at an edge where in_valid is high and in_stall is low. Each point
// gives exactly one request on the out_ channel: visibility, camera-frame
// point and pixel coordinates (zero when the depth is not positive).
// Stages: rotation and translation, focal product and rounding offset,
// quotient (one bit per stage for both axes), principal point and saturation.
// Throughput is one point per cycle while out_stall is low; the bit-serial
// divide pipeline sets the depth, not the rate. When out_stall is high,
// stages fill up behind the held result, and in_stall rises only once every
// stage holds a point. Configuration registers are written through
// cfg_wr_en/cfg_index/cfg_data while no point is in flight (by the user, not
// enforced by the block); indexes beyond the last register are ignored.
// Synchronous reset clears all valid bits and loads rotation rows (0,1,0),
// (0,0,1), (0,0,1) with zero translation, focal lengths and principal point.
// ----------------------------------------------------------------------------
module pinhole_point_projection (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_world_x,
  input  logic signed [31:0] in_world_y,
  input  logic signed [31:0] in_world_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_visible,
  output logic signed [31:0] out_cam_x,
  output logic signed [31:0] out_cam_y,
  output logic signed [31:0] out_cam_z,
  output logic signed [31:0] out_pixel_u,
  output logic signed [31:0] out_pixel_v,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import ppp_pkg::*;

  logic [47:0] rot_row0_r, rot_row1_r, rot_row2_r;
  logic [63:0] trans_xy_r, focal_xy_r, center_xy_r;
  logic [31:0] trans_z_r;
  logic        xf_rdy, xf_v, pj_rdy;
  cam_t        xf_cam, out_cam;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_row0_r  <= ROT_ROW0_RST;
      rot_row1_r  <= ROT_ROW1_RST;
      rot_row2_r  <= ROT_ROW2_RST;
      trans_xy_r  <= '0;
      trans_z_r   <= '0;
      focal_xy_r  <= '0;
      center_xy_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROT_ROW0:  rot_row0_r  <= cfg_data[47:0];
        REG_ROT_ROW1:  rot_row1_r  <= cfg_data[47:0];
        REG_ROT_ROW2:  rot_row2_r  <= cfg_data[47:0];
        REG_TRANS_XY:  trans_xy_r  <= cfg_data;
        REG_TRANS_Z:   trans_z_r   <= cfg_data[31:0];
        REG_FOCAL_XY:  focal_xy_r  <= cfg_data;
        REG_CENTER_XY: center_xy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !xf_rdy;

  ppp_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (xf_rdy),
    .world_x  (in_world_x),
    .world_y  (in_world_y),
    .world_z  (in_world_z),
    .rot_row0 (rot_row0_r),
    .rot_row1 (rot_row1_r),
    .rot_row2 (rot_row2_r),
    .trans_xy (trans_xy_r),
    .trans_z  (trans_z_r),
    .out_valid(xf_v),
    .out_ready(pj_rdy),
    .out_data (xf_cam)
  );

  ppp_project u_project (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (xf_v),
    .in_ready   (pj_rdy),
    .in_data    (xf_cam),
    .focal_xy   (focal_xy_r),
    .center_xy  (center_xy_r),
    .out_valid  (out_valid),
    .out_ready  (!out_stall),
    .out_visible(out_visible),
    .out_cam    (out_cam),
    .out_u      (out_pixel_u),
    .out_v      (out_pixel_v)
  );

  assign out_cam_x = out_cam.x;
  assign out_cam_y = out_cam.y;
  assign out_cam_z = out_cam.z;

endmodule

// ===== design/ppp_checker.sv =====
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks of the point projection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "pinhole_point_projection_assert.svh"

module ppp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_visible,
  input logic signed [31:0] out_cam_z,
  input logic signed [31:0] out_pixel_u,
  input logic signed [31:0] out_pixel_v
);

  `PPP_ASSERT(a_hold_valid, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `PPP_ASSERT(a_hidden_zero, out_valid && !out_visible |-> out_pixel_u == 0 && out_pixel_v == 0, "hidden point has pixel")
  `PPP_ASSERT(a_vis_depth, out_valid |-> out_visible == (!out_cam_z[31] && out_cam_z != 0), "visibility disagrees with depth")
  `PPP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result after reset")

endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pinhole point projection pipeline.
// ----------------------------------------------------------------------------
// World points are streamed through the block under several register
// settings: reset values, a plain camera, random poses and the extreme
// encodings. A bit-accurate predictor computes each expected camera point and
// pixel position, and results are compared in order as they leave the block.
// Both sides idle and stall at random, and in one phase the result side holds
// off long enough for the pipeline to fill and stall its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppp_pkg::*;

  typedef struct {
    logic               vis;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } projection_t;

  class projection_scoreboard;
    logic [47:0] rot0, rot1, rot2;
    logic [63:0] txy, fxy, cxy;
    logic [31:0] tz;
    projection_t awaited[$];
    int mismatches;
    int points_in;
    int points_out;
    int points_visible;

    function void load_reset();
      rot0 = ROT_ROW0_RST;
      rot1 = ROT_ROW1_RST;
      rot2 = ROT_ROW2_RST;
      txy  = '0;
      tz   = '0;
      fxy  = '0;
      cxy  = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        REG_ROT_ROW0:  rot0 = data[47:0];
        REG_ROT_ROW1:  rot1 = data[47:0];
        REG_ROT_ROW2:  rot2 = data[47:0];
        REG_TRANS_XY:  txy  = data;
        REG_TRANS_Z:   tz   = data[31:0];
        REG_FOCAL_XY:  fxy  = data;
        REG_CENTER_XY: cxy  = data;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // Q2.14 times Q16.16 sums exactly, then one round to Q16.16, ties upward.
    function logic signed [31:0] rotate_row(logic [47:0] row, logic signed [31:0] t,
                                            logic signed [31:0] x, logic signed [31:0] y,
                                            logic signed [31:0] z);
      longint acc;
      acc = longint'($signed(row[47:32])) * longint'(x)
          + longint'($signed(row[31:16])) * longint'(y)
          + longint'($signed(row[15:0])) * longint'(z)
          + longint'(t) * 64'sd16384;
      acc = (acc + 64'sd8192) >>> 14;
      return clamp32(acc);
    endfunction

    // Quotient magnitude is rounded half away from zero before the sign.
    function logic signed [31:0] pixel_coord(logic [31:0] f, logic signed [31:0] c,
                                             logic signed [31:0] z,
                                             logic signed [31:0] ctr);
      longint          cl;
      longint unsigned mag;
      longint unsigned uz;
      longint unsigned q;
      longint          sq;
      cl  = c;
      mag = (cl < 0) ? -cl : cl;
      uz  = longint'(z);
      q   = ({32'd0, f} * mag + uz / 2) / uz;
      if (q > 64'd8589934592) q = 64'd8589934592;
      sq  = (cl < 0) ? -longint'(q) : longint'(q);
      return clamp32(sq + longint'($signed(ctr)));
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      projection_t e;
      e.cx  = rotate_row(rot0, txy[63:32], x, y, z);
      e.cy  = rotate_row(rot1, txy[31:0], x, y, z);
      e.cz  = rotate_row(rot2, tz, x, y, z);
      e.vis = (e.cz > 0);
      e.u   = '0;
      e.v   = '0;
      if (e.vis) begin
        e.u = pixel_coord(fxy[63:32], e.cx, e.cz, cxy[63:32]);
        e.v = pixel_coord(fxy[31:0], e.cy, e.cz, cxy[31:0]);
        points_visible++;
      end
      awaited.push_back(e);
      points_in++;
    endfunction

    function void check_result(projection_t got);
      projection_t e;
      points_out++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: no request pending");
        return;
      end
      e = awaited.pop_front();
      if (got.vis !== e.vis || got.cx !== e.cx || got.cy !== e.cy || got.cz !== e.cz ||
          got.u !== e.u || got.v !== e.v) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d:", points_out);
          $display("  expected vis=%0b cam=(%h %h %h) pix=(%h %h)",
                   e.vis, e.cx, e.cy, e.cz, e.u, e.v);
          $display("  actual   vis=%0b cam=(%h %h %h) pix=(%h %h)",
                   got.vis, got.cx, got.cy, got.cz, got.u, got.v);
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_world_x;
  logic signed [31:0] in_world_y;
  logic signed [31:0] in_world_z;
  logic               out_valid;
  logic               out_stall;
  logic               out_visible;
  logic signed [31:0] out_cam_x;
  logic signed [31:0] out_cam_y;
  logic signed [31:0] out_cam_z;
  logic signed [31:0] out_pixel_u;
  logic signed [31:0] out_pixel_v;
  logic               cfg_wr_en;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;

  projection_scoreboard sb;
  bit quiet;          // no idling on either side while set
  int hold_cycles;    // long receiver hold-off, counted down by the stall process

  pinhole_point_projection u_dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int left;
    out_stall = 1'b0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
        left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    projection_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.vis = out_visible;
      got.cx  = out_cam_x;
      got.cy  = out_cam_y;
      got.cz  = out_cam_z;
      got.u   = out_pixel_u;
      got.v   = out_pixel_v;
      sb.check_result(got);
    end
  end

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_world_x <= x;
    in_world_y <= y;
    in_world_z <= z;
    do @(posedge clk); while (in_stall);
    sb.note_point(x, y, z);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    @(negedge clk);
  endtask

  // The enable drops for one cycle between writes.
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 1)) return $urandom;
    return $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
  endfunction

  // Small rotation entries keep the depth moderate so that many points project.
  function automatic logic [47:0] rand_row();
    logic [47:0] r;
    if ($urandom_range(0, 2) == 0) return 48'(rand64());
    for (int i = 0; i < 3; i++) begin
      r[16*i +: 16] = 16'($urandom_range(0, 16'h7FFF)) - 16'h4000;
    end
    return r;
  endfunction

  task automatic random_pose();
    write_reg(REG_ROT_ROW0, 64'(rand_row()));
    write_reg(REG_ROT_ROW1, 64'(rand_row()));
    write_reg(REG_ROT_ROW2, 64'(rand_row()));
    write_reg(REG_TRANS_XY, rand64());
    write_reg(REG_TRANS_Z, {$urandom, $urandom});
    write_reg(REG_FOCAL_XY, rand64());
    write_reg(REG_CENTER_XY, rand64());
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 80 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    quiet = 1'b0;
  endtask

  initial begin
    sb = new();
    sb.load_reset();
    quiet       = 1'b0;
    hold_cycles = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_world_x  = '0;
    in_world_y  = '0;
    in_world_z  = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: rotation rows (0,1,0), (0,0,1), (0,0,1), zero focal lengths.
    send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000);
    random_points(40);
    drain();

    // Plain camera: identity, f = 500, center (320, 240), 5 units in front.
    write_reg(REG_ROT_ROW0, 64'h0000_4000_0000_0000);
    write_reg(REG_ROT_ROW1, 64'h0000_0000_4000_0000);
    write_reg(REG_ROT_ROW2, 64'h0000_0000_0000_4000);
    write_reg(REG_TRANS_XY, 64'h0000_0000_0000_0000);
    write_reg(REG_TRANS_Z, 64'h0000_0000_0005_0000);
    write_reg(REG_FOCAL_XY, {32'h01F4_0000, 32'h01F4_0000});
    write_reg(REG_CENTER_XY, {32'h0140_0000, 32'h00F0_0000});
    write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);   // unused index must not disturb
    send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
    send_point(32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_0000);
    send_point(32'sh0000_0000, 32'sh0000_0000, 32'shFFFB_0000);  // zero depth
    send_point(32'sh0000_0000, 32'sh0000_0000, 32'shFFFA_0000);  // behind the camera
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFB_0001);  // huge quotient
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFB_0001);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);  // saturated depth
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_0000);
    send_point(32'sh0000_0003, 32'sh0000_0007, 32'sh0005_0000);  // small offsets, exact quotient
    send_point(32'sh0002_8000, 32'shFFFD_8000, 32'sh0000_0001);
    send_point(32'sh1234_5678, 32'shEDCB_A988, 32'h0100_0000);
    random_points(200);
    drain();

    // Random poses, one of them with a long receiver hold-off.
    for (int ph = 0; ph < 4; ph++) begin
      random_pose();
      if (ph == 1) hold_cycles = 400;
      random_points(250);
      drain();
    end

    // Extreme encodings: most negative and most positive entries everywhere.
    write_reg(REG_ROT_ROW0, 64'h0000_8000_8000_8000);
    write_reg(REG_ROT_ROW1, 64'h0000_7FFF_7FFF_7FFF);
    write_reg(REG_ROT_ROW2, 64'h0000_7FFF_8000_7FFF);
    write_reg(REG_TRANS_XY, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_TRANS_Z, 64'hFFFF_FFFF_8000_0000);
    write_reg(REG_FOCAL_XY, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CENTER_XY, {32'h7FFF_FFFF, 32'h8000_0000});
    random_points(150);
    drain();
    write_reg(REG_ROT_ROW0, 64'h0000_FFFF_FFFF_FFFF);
    write_reg(REG_ROT_ROW1, 64'h0000_0000_0000_0000);
    write_reg(REG_ROT_ROW2, 64'h0000_0001_0001_0001);
    write_reg(REG_TRANS_XY, 64'h8000_0000_7FFF_FFFF);
    write_reg(REG_TRANS_Z, 64'h0000_0000_7FFF_FFFF);
    write_reg(REG_FOCAL_XY, 64'h0000_0001_0000_0000);
    write_reg(REG_CENTER_XY, 64'h8000_0000_7FFF_FFFF);
    random_points(150);
    drain();

    $display("%0d points projected under eight register settings, %0d of them visible;",
             sb.points_in, sb.points_visible);
    $display("one phase held results back until the input stalled.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[pinhole_point_projection] OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[pinhole_point_projection] ERROR");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("timeout");
    $display("[pinhole_point_projection] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ppp_pkg.sv
design/ppp_xform.sv
design/ppp_divstep.sv
design/ppp_project.sv
design/pinhole_point_projection.sv
design/ppp_checker.sv
tb/sv/tb.sv
